// ===== src/ising_pkg.sv =====
// ============================================================================
// Ising spin update package
// Shared widths, operation and register codes, and the trial decision record.
// ============================================================================
package ising_pkg;

    // Field widths
    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;
    localparam int COORD_SPAN = 1 << COORD_W;
    localparam int PROB_BITS = 16;
    localparam int CHG_W     = 4;
    localparam int ENERGY_W  = 15;
    localparam int MAGNET_W  = 14;
    localparam int SUM_W     = 16;   // headroom for total plus one increment
    localparam int CFG_IDX_W = 1;

    // Saturation bounds of the running totals
    localparam int ENERGY_LIMIT = 8192;
    localparam int MAGNET_LIMIT = 4096;

    // Operation codes; anything else behaves as a read
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_TRIAL = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_TWO  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_FOUR = 1'd1;

    // Reset values of the acceptance probabilities
    localparam logic [PROB_BITS-1:0] ACCEPT_TWO_RST  = 16'd24417;
    localparam logic [PROB_BITS-1:0] ACCEPT_FOUR_RST = 16'd9097;

    typedef struct packed {
        logic                    accept;
        logic signed [CHG_W-1:0] change;
    } ising_dec_t;

endpackage

// ===== src/ising_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port, read data registered (read-first).
// ============================================================================
module ising_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ising_decide.sv =====
// ============================================================================
// Metropolis trial decision
// Local change from centre and neighbour spins, and the acceptance test.
// ============================================================================
module ising_decide (
    input  logic                               centre,
    input  logic [3:0]                         neighbours,
    input  logic [ising_pkg::PROB_BITS-1:0]    random_value,
    input  logic [ising_pkg::PROB_BITS-1:0]    prob_two,
    input  logic [ising_pkg::PROB_BITS-1:0]    prob_four,
    output ising_pkg::ising_dec_t              decision
);
    import ising_pkg::*;

    logic [2:0]              up_count;
    logic signed [CHG_W-1:0] nsum;
    logic signed [CHG_W-1:0] change;

    always_comb
    begin
        up_count = 3'(neighbours[0]) + 3'(neighbours[1])
                 + 3'(neighbours[2]) + 3'(neighbours[3]);
        // sum of +-1 neighbours = 2*ups - 4
        nsum     = $signed({up_count, 1'b0}) - 4'sd4;
        change   = centre ? nsum : -nsum;

        decision.change = change;
        if (change <= 4'sd0)
        begin
            decision.accept = 1'b1;
        end
        else if (change == 4'sd2)
        begin
            decision.accept = (prob_two >= random_value);
        end
        else
        begin
            decision.accept = (prob_four >= random_value);
        end
    end

endmodule

// ===== src/ising_metropolis_spin_update.sv =====
// ============================================================================
// Ising Metropolis single-spin-flip engine
// Toroidal SIDE x SIDE spin lattice with load, read and Metropolis trial.
// ============================================================================
// Usage notes
//  - Command channel: an item transfers on a rising edge with start high and
//    busy low. Fields: op, col, row, load_spin, random_value.
//  - Result channel: done pulses for one cycle with flipped, local_change,
//    spin_now and the two running totals. The receiver cannot stall it, so
//    results must be taken in the cycle they appear.
//  - Pipeline: command register, then decision and result register. One item
//    is accepted every cycle while busy is low; there is no stall between
//    back-to-back commands, even on neighbouring sites.
//  - The lattice is held as rows of SIDE bits in three RAM copies, giving the
//    row above, the site's row and the row below in one read. The row just
//    written is forwarded to the following item.
//  - Configuration: cfg_valid/cfg_index/cfg_data, cfg_ready always high.
//    Write only while idle.
//  - Reset: totals clear, probabilities take their defaults and a clearing
//    pass zeroes the lattice one row at a time (all spins -1). busy is high
//    during that pass.
// ============================================================================
module ising_metropolis_spin_update #(
    parameter int SIDE = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // command channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ising_pkg::OP_W-1:0]           op,
    input  logic [ising_pkg::COORD_W-1:0]        col,
    input  logic [ising_pkg::COORD_W-1:0]        row,
    input  logic                                 load_spin,
    input  logic [ising_pkg::PROB_BITS-1:0]      random_value,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ising_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ising_pkg::PROB_BITS-1:0]      cfg_data,
    // result channel
    output logic                                 done,
    output logic                                 flipped,
    output logic signed [ising_pkg::CHG_W-1:0]   local_change,
    output logic                                 spin_now,
    output logic signed [ising_pkg::ENERGY_W-1:0] energy_delta_total,
    output logic signed [ising_pkg::MAGNET_W-1:0] magnet_delta_total
);
    import ising_pkg::*;

    localparam int CW = $clog2(SIDE);
    localparam logic [CW-1:0] LAST = CW'(SIDE - 1);

    // ------------------------------------------------------------------
    // Coordinate reduction: constant table of i mod SIDE
    // ------------------------------------------------------------------
    logic [CW-1:0] coord_mod [COORD_SPAN];

    for (genvar i = 0; i < COORD_SPAN; i++)
    begin : g_mod
        assign coord_mod[i] = CW'(i % SIDE);
    end

    logic [CW-1:0] in_x;
    logic [CW-1:0] in_y;
    logic [CW-1:0] in_y_up;
    logic [CW-1:0] in_y_dn;
    logic          accept_in;

    assign in_x      = coord_mod[col];
    assign in_y      = coord_mod[row];
    assign in_y_up   = (in_y == '0)   ? LAST : in_y - CW'(1);
    assign in_y_dn   = (in_y == LAST) ? '0   : in_y + CW'(1);
    assign accept_in = start && !busy;

    // ------------------------------------------------------------------
    // Control and configuration state
    // ------------------------------------------------------------------
    logic                   clearing_reg;
    logic [CW-1:0]          clr_cnt_reg;
    logic [PROB_BITS-1:0]   prob_two_reg;
    logic [PROB_BITS-1:0]   prob_four_reg;

    assign busy      = clearing_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + CW'(1);
            if (clr_cnt_reg == LAST)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_two_reg  <= ACCEPT_TWO_RST;
            prob_four_reg <= ACCEPT_FOUR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACCEPT_TWO:  prob_two_reg  <= cfg_data;
                REG_ACCEPT_FOUR: prob_four_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: command register, row reads in flight
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic [OP_W-1:0]      s1_op_reg;
    logic [CW-1:0]        s1_x_reg;
    logic [CW-1:0]        s1_y_reg;
    logic [CW-1:0]        s1_y_up_reg;
    logic [CW-1:0]        s1_y_dn_reg;
    logic                 s1_lspin_reg;
    logic [PROB_BITS-1:0] s1_rnd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_op_reg    <= op;
            s1_x_reg     <= in_x;
            s1_y_reg     <= in_y;
            s1_y_up_reg  <= in_y_up;
            s1_y_dn_reg  <= in_y_dn;
            s1_lspin_reg <= load_spin;
            s1_rnd_reg   <= random_value;
        end
    end

    // ------------------------------------------------------------------
    // Lattice rows: three identical copies, one read port each
    // ------------------------------------------------------------------
    logic            wr_en;
    logic [CW-1:0]   wr_addr;
    logic [SIDE-1:0] wr_data;
    logic [SIDE-1:0] ram_up;
    logic [SIDE-1:0] ram_mid;
    logic [SIDE-1:0] ram_dn;

    ising_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_up (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (in_y_up),
        .rd_data (ram_up)
    );

    ising_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_mid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (in_y),
        .rd_data (ram_mid)
    );

    ising_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_dn (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (in_y_dn),
        .rd_data (ram_dn)
    );

    // Write of the previous cycle, missed by the read-first RAM
    logic            fwd_valid_reg;
    logic [CW-1:0]   fwd_row_reg;
    logic [SIDE-1:0] fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_row_reg  <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    logic [SIDE-1:0] row_up;
    logic [SIDE-1:0] row_mid;
    logic [SIDE-1:0] row_dn;

    assign row_up  = (fwd_valid_reg && fwd_row_reg == s1_y_up_reg) ? fwd_data_reg : ram_up;
    assign row_mid = (fwd_valid_reg && fwd_row_reg == s1_y_reg)    ? fwd_data_reg : ram_mid;
    assign row_dn  = (fwd_valid_reg && fwd_row_reg == s1_y_dn_reg) ? fwd_data_reg : ram_dn;

    // ------------------------------------------------------------------
    // Stage 2: decision, lattice write, totals, result register
    // ------------------------------------------------------------------
    logic [CW-1:0] x_left;
    logic [CW-1:0] x_right;
    logic          centre;
    logic [3:0]    nbrs;
    ising_dec_t    dec;

    assign x_left  = (s1_x_reg == '0)   ? LAST : s1_x_reg - CW'(1);
    assign x_right = (s1_x_reg == LAST) ? '0   : s1_x_reg + CW'(1);
    assign centre  = row_mid[s1_x_reg];
    assign nbrs    = {row_mid[x_left], row_mid[x_right],
                      row_up[s1_x_reg], row_dn[s1_x_reg]};

    ising_decide u_decide (
        .centre       (centre),
        .neighbours   (nbrs),
        .random_value (s1_rnd_reg),
        .prob_two     (prob_two_reg),
        .prob_four    (prob_four_reg),
        .decision     (dec)
    );

    logic                       is_load;
    logic                       is_trial;
    logic                       flip;
    logic                       new_spin;
    logic [SIDE-1:0]            new_row;
    logic signed [ENERGY_W-1:0] energy_reg;
    logic signed [ENERGY_W-1:0] energy_next;
    logic signed [MAGNET_W-1:0] magnet_reg;
    logic signed [MAGNET_W-1:0] magnet_next;
    logic signed [SUM_W-1:0]    energy_sum;
    logic signed [SUM_W-1:0]    magnet_sum;

    assign is_load  = (s1_op_reg == OP_LOAD);
    assign is_trial = (s1_op_reg == OP_TRIAL);
    assign flip     = is_trial && dec.accept;
    // load stores the given spin; a flip inverts; otherwise unchanged
    assign new_spin = is_load ? s1_lspin_reg : (centre ^ flip);

    always_comb
    begin
        new_row           = row_mid;
        new_row[s1_x_reg] = new_spin;
    end

    assign wr_en   = clearing_reg || (s1_valid_reg && (is_load || flip));
    assign wr_addr = clearing_reg ? clr_cnt_reg : s1_y_reg;
    assign wr_data = clearing_reg ? '0 : new_row;

    // Saturating totals, cleared by a load; on a flip magnetisation gains the new spin (+1 or -1)
    always_comb
    begin
        energy_sum = SUM_W'(energy_reg) + SUM_W'(dec.change);
        magnet_sum = SUM_W'(magnet_reg) + (centre ? -16'sd1 : 16'sd1);

        energy_next = energy_reg;
        magnet_next = magnet_reg;
        if (is_load)
        begin
            energy_next = '0;
            magnet_next = '0;
        end
        else if (flip)
        begin
            if (energy_sum > SUM_W'(ENERGY_LIMIT))
                energy_next = ENERGY_W'(ENERGY_LIMIT);
            else if (energy_sum < -SUM_W'(ENERGY_LIMIT))
                energy_next = -ENERGY_W'(ENERGY_LIMIT);
            else
                energy_next = ENERGY_W'(energy_sum);

            if (magnet_sum > SUM_W'(MAGNET_LIMIT))
                magnet_next = MAGNET_W'(MAGNET_LIMIT);
            else if (magnet_sum < -SUM_W'(MAGNET_LIMIT))
                magnet_next = -MAGNET_W'(MAGNET_LIMIT);
            else
                magnet_next = MAGNET_W'(magnet_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            magnet_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            energy_reg <= energy_next;
            magnet_reg <= magnet_next;
        end
    end

    // Result register
    logic                    done_reg;
    logic                    flipped_reg;
    logic signed [CHG_W-1:0] change_reg;
    logic                    spin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            flipped_reg <= flip;
            change_reg  <= is_trial ? dec.change : '0;
            spin_reg    <= new_spin;
        end
    end

    assign done               = done_reg;
    assign flipped            = flipped_reg;
    assign local_change       = change_reg;
    assign spin_now           = spin_reg;
    assign energy_delta_total = energy_reg;
    assign magnet_delta_total = magnet_reg;

endmodule
